// ===== design/sdwo_pkg.sv =====
// Shared types and constants for the signed divider with overflow.
package sdwo_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CNT_W   = $clog2(DATA_W);
    localparam int unsigned SAR_AMT = 29;
    localparam int unsigned ROT_AMT = DATA_W - SAR_AMT;

    localparam logic [DATA_W-1:0] MIN_PATTERN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MAX_PATTERN = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [CNT_W-1:0]  LAST_STEP   = CNT_W'(DATA_W - 1);

    typedef struct packed {
        logic signed [DATA_W-1:0] dividend;
        logic signed [DATA_W-1:0] divisor;
    } sdwo_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] quotient;
        logic signed [DATA_W-1:0] remainder;
        logic                     overflow_flag;
        logic                     irq_request;
    } sdwo_out_t;

    typedef struct packed {
        logic running;
        logic done;
    } sdwo_core_sts_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } sdwo_state_t;

endpackage

// ===== design/signed_divider_with_overflow.sv =====
// Top level: signed 32-bit divider with sticky divide-by-zero flag and interrupt.
//
// Usage:
//   Input word (dividend, divisor) is taken on a rising edge with start high
//   and busy low. busy stays high until the result is out.
//   The result word appears on result for exactly one cycle with done high;
//   the receiver cannot stall, so it must take the word in that cycle.
//   A nonzero divisor is loaded into the divide core, which makes one quotient
//   bit per cycle on its shared subtractor; the sign fix-up and the output
//   register follow. A zero divisor skips the core. A new word may be started
//   in the cycle done is high.
//   cfg_we writes cfg_wdata to the overflow interrupt enable; write only
//   while idle.
//   Reset clears the enable, the sticky overflow flag and the sequencer.
module signed_divider_with_overflow (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sdwo_pkg::sdwo_in_t  operands,
    output logic                done,
    output sdwo_pkg::sdwo_out_t result,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    sdwo_pkg::sdwo_state_t          state_reg, state_next;
    logic                           irq_en_reg;
    logic                           sticky_reg, sticky_next;
    logic                           done_reg, done_next;
    sdwo_pkg::sdwo_out_t            res_reg, res_next;
    logic [sdwo_pkg::DATA_W-1:0]    a_reg, a_next;
    logic                           a_neg_reg, a_neg_next;
    logic                           b_neg_reg, b_neg_next;
    logic                           zero_reg, zero_next;

    logic                           accept;
    logic                           div_zero;
    logic                           core_load;
    logic [sdwo_pkg::DATA_W-1:0]    ua, ub;
    sdwo_pkg::sdwo_core_sts_t       core_sts;
    logic [sdwo_pkg::DATA_W-1:0]    uquo, urem;
    logic [sdwo_pkg::DATA_W-1:0]    q_val, r_val;

    assign div_zero = (operands.divisor == '0);
    assign ua = operands.dividend[sdwo_pkg::DATA_W-1] ? -operands.dividend : operands.dividend;
    assign ub = operands.divisor[sdwo_pkg::DATA_W-1]  ? -operands.divisor  : operands.divisor;

    sdwo_divcore u_divcore (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (core_load),
        .num   (ua),
        .den   (ub),
        .sts   (core_sts),
        .uquo  (uquo),
        .urem  (urem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sdwo_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = div_zero ? sdwo_pkg::ST_FINISH : sdwo_pkg::ST_DIVIDE;
            end
            sdwo_pkg::ST_DIVIDE:
            begin
                if (core_sts.done)
                    state_next = sdwo_pkg::ST_FINISH;
            end
            sdwo_pkg::ST_FINISH:
                state_next = sdwo_pkg::ST_IDLE;
            default:
                state_next = sdwo_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy      = 1'b1;
        core_load = 1'b0;
        case (state_reg)
            sdwo_pkg::ST_IDLE:
            begin
                busy      = 1'b0;
                core_load = start && !div_zero;
            end
            sdwo_pkg::ST_DIVIDE,
            sdwo_pkg::ST_FINISH:
                busy = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

    assign accept = start && !busy;

    // result formation
    always_comb
    begin
        if (zero_reg)
        begin
            r_val = {{sdwo_pkg::SAR_AMT{a_reg[sdwo_pkg::DATA_W-1]}},
                     a_reg[sdwo_pkg::DATA_W-1:sdwo_pkg::SAR_AMT]};
            if (irq_en_reg)
                q_val = {a_reg[sdwo_pkg::DATA_W-sdwo_pkg::ROT_AMT-1:0],
                         {sdwo_pkg::ROT_AMT{a_reg[sdwo_pkg::DATA_W-1]}}};
            else
                q_val = a_neg_reg ? sdwo_pkg::MIN_PATTERN : sdwo_pkg::MAX_PATTERN;
        end
        else
        begin
            q_val = (a_neg_reg ^ b_neg_reg) ? -uquo : uquo;
            r_val = a_neg_reg ? -urem : urem;
        end
    end

    always_comb
    begin
        a_next      = a_reg;
        a_neg_next  = a_neg_reg;
        b_neg_next  = b_neg_reg;
        zero_next   = zero_reg;
        sticky_next = sticky_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        if (accept)
        begin
            a_next     = operands.dividend;
            a_neg_next = operands.dividend[sdwo_pkg::DATA_W-1];
            b_neg_next = operands.divisor[sdwo_pkg::DATA_W-1];
            zero_next  = div_zero;
        end
        if (state_reg == sdwo_pkg::ST_FINISH)
        begin
            sticky_next            = sticky_reg | zero_reg;
            done_next              = 1'b1;
            res_next.quotient      = q_val;
            res_next.remainder     = r_val;
            res_next.overflow_flag = sticky_next;
            res_next.irq_request   = sticky_next & irq_en_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sdwo_pkg::ST_IDLE;
            irq_en_reg <= 1'b0;
            sticky_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sticky_reg <= sticky_next;
            done_reg   <= done_next;
            if (cfg_we)
                irq_en_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        a_neg_reg <= a_neg_next;
        b_neg_reg <= b_neg_next;
        zero_reg  <= zero_next;
        res_reg   <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(sticky_reg))
        else $error("sticky overflow flag cleared");

    a_irq_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.irq_request) |-> result.overflow_flag)
        else $error("irq without overflow flag");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("not busy after accept");

endmodule

// ===== design/sdwo_divcore.sv =====
// Unsigned restoring divider: one quotient bit per cycle on a shared subtractor.
module sdwo_divcore (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [sdwo_pkg::DATA_W-1:0]   num,
    input  logic [sdwo_pkg::DATA_W-1:0]   den,
    output sdwo_pkg::sdwo_core_sts_t      sts,
    output logic [sdwo_pkg::DATA_W-1:0]   uquo,
    output logic [sdwo_pkg::DATA_W-1:0]   urem
);

    logic                          running_reg, running_next;
    logic                          done_reg, done_next;
    logic [sdwo_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [sdwo_pkg::DATA_W-1:0]   quo_reg, quo_next;
    logic [sdwo_pkg::DATA_W-1:0]   rem_reg, rem_next;
    logic [sdwo_pkg::DATA_W-1:0]   den_reg, den_next;
    logic [sdwo_pkg::DATA_W:0]     partial;
    logic [sdwo_pkg::DATA_W+1:0]   diff;
    logic                          borrow;

    assign partial = {rem_reg, quo_reg[sdwo_pkg::DATA_W-1]};
    assign diff    = {1'b0, partial} - {2'b00, den_reg};
    assign borrow  = diff[sdwo_pkg::DATA_W+1];

    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        if (load)
        begin
            running_next = 1'b1;
            count_next   = '0;
            quo_next     = num;
            rem_next     = '0;
            den_next     = den;
        end
        else if (running_reg)
        begin
            quo_next   = {quo_reg[sdwo_pkg::DATA_W-2:0], ~borrow};
            rem_next   = borrow ? partial[sdwo_pkg::DATA_W-1:0] : diff[sdwo_pkg::DATA_W-1:0];
            count_next = count_reg + 1'b1;
            if (count_reg == sdwo_pkg::LAST_STEP)
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign sts.running = running_reg;
    assign sts.done    = done_reg;
    assign uquo        = quo_reg;
    assign urem        = rem_reg;

endmodule
